[hdl/sbcpu_pkg.sv]
// ----------------------------------------------------------------------------
// sbcpu_pkg
// Shared types and constants of the 16-bit CPU execute block: instruction and
// result payloads, opcodes and the data memory request bundle.
// ----------------------------------------------------------------------------
package sbcpu_pkg;

  localparam logic [15:0] HI_MASK = 16'hFF00;
  localparam logic [15:0] LO_MASK = 16'h00FF;
  localparam int unsigned BYTE_W  = 8;

  typedef enum logic [3:0] {
    OP_NOOP = 4'd0,
    OP_ADD  = 4'd1,
    OP_MOVL = 4'd2,
    OP_MOVH = 4'd3,
    OP_LW   = 4'd4,
    OP_SW   = 4'd5,
    OP_JMP  = 4'd6,
    OP_JR   = 4'd7,
    OP_BEQ  = 4'd8,
    OP_INT  = 4'd9
  } op_e;

  typedef struct packed {
    logic [3:0]  mode;
    logic [3:0]  dest_reg;
    logic [3:0]  src_a_reg;
    logic [3:0]  src_b_reg;
    logic [7:0]  immediate;
    logic [15:0] offset;
    logic [15:0] jump_target;
  } instr_t;

  typedef struct packed {
    logic [15:0] next_pc;
    logic        halted;
    logic        bad_opcode;
    logic        bad_target;
    logic        syscall_request;
    logic [3:0]  syscall_number;
    logic [7:0]  syscall_argument;
  } result_t;

  // one access per cycle; addr is the raw 16-bit sum, reduced inside the memory
  typedef struct packed {
    logic        wr;
    logic        rd;
    logic [15:0] addr;
    logic [15:0] wdata;
  } dmem_req_t;

endpackage

[hdl/sixteen_bit_cpu_execute.sv]
// ----------------------------------------------------------------------------
// sixteen_bit_cpu_execute
// Execute stage of a small 16-bit CPU: program counter, register file and
// data memory, one decoded instruction in, one status result out.
// ----------------------------------------------------------------------------
// Usage:
//   in_data_i carries a decoded instruction; a transfer happens on a rising
//   edge with in_valid_i high and in_stall_o low. out_data_o carries the
//   counter and status flags of each instruction; the receiver holds it with
//   out_stall_i. cfg_we_i writes program_words from cfg_wdata_i at any edge;
//   change it only while the block is idle.
//   The input transfer registers the instruction and its register file reads;
//   the result is registered when execute commits. No new instruction is
//   taken while one is in execute. A load writes back in the cycle after
//   execute, overlapping the next instruction's register read (forwarded).
//   A waiting result does not block the next input transfer; only a second
//   result with the first still stalled holds the execute cycle, and with it
//   further input.
//   Reset: counter and program_words go to zero and registers read as zero;
//   the data memory is then cleared one word per cycle, with in_stall_o
//   high throughout.
// ----------------------------------------------------------------------------
module sixteen_bit_cpu_execute import sbcpu_pkg::*; #(
  parameter int unsigned NUM_REGS  = 16,
  parameter int unsigned MEM_WORDS = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  instr_t      in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output result_t     out_data_o,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);

  localparam int unsigned RIDX = $clog2(NUM_REGS);

  logic [15:0]   pwords_q;
  logic [15:0]   pc_q;
  logic [15:0]   pc_d;
  logic          ex_q;
  logic          wb_q;
  logic [3:0]    wb_reg_q;
  logic          out_valid_q;
  result_t       out_q;
  result_t       res;
  instr_t        instr_q;

  logic [15:0]   rf_q [NUM_REGS];
  logic          rf_vld_q [NUM_REGS];
  logic [15:0]   rdat0_q;
  logic [15:0]   rdat1_q;
  logic [3:0]    raddr0;
  logic [3:0]    raddr1;
  logic          rf_we;
  logic [3:0]    rf_waddr;
  logic [15:0]   rf_wdata;
  logic          ex_we;
  logic [15:0]   ex_wdata;

  dmem_req_t     dreq;
  logic [15:0]   drdata;
  logic          dbusy;

  logic          accept;
  logic          commit;
  logic [15:0]   pc_inc;
  logic          halt;
  logic          jump;
  logic [15:0]   dest;

  sbcpu_dmem #(
    .MEM_WORDS (MEM_WORDS)
  ) u_dmem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (dreq),
    .rdata_o (drdata),
    .busy_o  (dbusy)
  );

  assign in_stall_o  = ex_q || dbusy;
  assign accept      = in_valid_i && !in_stall_o;
  assign commit      = ex_q && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // port 0 reads the second addend for add, the first register field otherwise
  assign raddr0 = (in_data_i.mode == OP_ADD) ? in_data_i.src_b_reg : in_data_i.dest_reg;
  assign raddr1 = in_data_i.src_a_reg;

  // execute
  always_comb begin
    pc_inc   = pc_q + 16'd1;
    halt     = pc_inc > pwords_q;
    pc_d     = pc_inc;
    jump     = 1'b0;
    dest     = '0;
    ex_we    = 1'b0;
    ex_wdata = '0;
    dreq     = '0;
    res      = '0;
    res.halted = halt;
    if (!halt) begin
      case (instr_q.mode)
        OP_NOOP: ;
        OP_ADD: begin
          ex_we    = 1'b1;
          ex_wdata = rdat0_q + rdat1_q;
        end
        OP_MOVL: begin
          ex_we    = 1'b1;
          ex_wdata = (rdat0_q & HI_MASK) | {8'd0, instr_q.immediate};
        end
        OP_MOVH: begin
          ex_we    = 1'b1;
          ex_wdata = (rdat0_q & LO_MASK) | ({8'd0, instr_q.immediate} << BYTE_W);
        end
        OP_LW: begin
          dreq.rd   = commit;
          dreq.addr = rdat1_q + instr_q.offset;
        end
        OP_SW: begin
          dreq.wr    = commit;
          dreq.addr  = rdat0_q + instr_q.offset;
          dreq.wdata = rdat1_q;
        end
        OP_JMP: begin
          jump = 1'b1;
          dest = instr_q.jump_target;
        end
        OP_JR: begin
          jump = 1'b1;
          dest = rdat0_q + {8'd0, instr_q.immediate};
        end
        OP_BEQ: begin
          if (rdat0_q == rdat1_q) begin
            jump = 1'b1;
            dest = pc_inc + instr_q.offset;
          end
        end
        OP_INT: begin
          res.syscall_request  = 1'b1;
          res.syscall_number   = instr_q.dest_reg;
          res.syscall_argument = instr_q.immediate;
        end
        default: begin
          res.bad_opcode = 1'b1;
          pc_d           = pwords_q;
        end
      endcase
      if (jump) begin
        pc_d           = dest;
        res.bad_target = dest > pwords_q;
      end
    end
    res.next_pc = pc_d;
  end

  // single register file write port: load writeback or execute result
  always_comb begin
    if (wb_q) begin
      rf_waddr = wb_reg_q;
      rf_wdata = drdata;
      rf_we    = 32'(wb_reg_q) < NUM_REGS;
    end else begin
      rf_waddr = instr_q.dest_reg;
      rf_wdata = ex_wdata;
      rf_we    = commit && ex_we && (32'(instr_q.dest_reg) < NUM_REGS);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rf_we) rf_q[rf_waddr[RIDX-1:0]] <= rf_wdata;
    if (accept) begin
      instr_q <= in_data_i;
      if (rf_we && rf_waddr == raddr0) begin
        rdat0_q <= rf_wdata;
      end else if (32'(raddr0) < NUM_REGS && rf_vld_q[raddr0[RIDX-1:0]]) begin
        rdat0_q <= rf_q[raddr0[RIDX-1:0]];
      end else begin
        rdat0_q <= '0;
      end
      if (rf_we && rf_waddr == raddr1) begin
        rdat1_q <= rf_wdata;
      end else if (32'(raddr1) < NUM_REGS && rf_vld_q[raddr1[RIDX-1:0]]) begin
        rdat1_q <= rf_q[raddr1[RIDX-1:0]];
      end else begin
        rdat1_q <= '0;
      end
    end
    if (commit) begin
      out_q    <= res;
      wb_reg_q <= instr_q.dest_reg;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGS; i++) rf_vld_q[i] <= 1'b0;
    end else if (rf_we) begin
      rf_vld_q[rf_waddr[RIDX-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pwords_q    <= '0;
      pc_q        <= '0;
      ex_q        <= 1'b0;
      wb_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) pwords_q <= cfg_wdata_i;
      if (accept) begin
        ex_q <= 1'b1;
      end else if (commit) begin
        ex_q <= 1'b0;
      end
      wb_q <= commit && !halt && (instr_q.mode == OP_LW);
      if (commit) begin
        pc_q        <= pc_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

[hdl/sbcpu_dmem.sv]
// ----------------------------------------------------------------------------
// sbcpu_dmem
// Word-addressed data memory, one access per cycle, registered read data.
// Reduces the 16-bit address modulo the depth and zeroes itself after reset.
// ----------------------------------------------------------------------------
module sbcpu_dmem import sbcpu_pkg::*; #(
  parameter int unsigned MEM_WORDS = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  dmem_req_t   req_i,
  output logic [15:0] rdata_o,
  output logic        busy_o
);

  localparam int unsigned AW = $clog2(MEM_WORDS);

  typedef logic [AW-1:0] mtab_t [256];

  // residues of i*step for i = 0..255, built by running sums
  function automatic mtab_t build_tab(int unsigned step);
    mtab_t       tab;
    int unsigned acc;
    int unsigned s;
    acc = 0;
    s   = step;
    for (int k = 0; k < 16; k++) begin
      if (s >= MEM_WORDS) s = s - MEM_WORDS;
    end
    for (int i = 0; i < 256; i++) begin
      tab[i] = AW'(acc);
      acc    = acc + s;
      if (acc >= MEM_WORDS) acc = acc - MEM_WORDS;
    end
    return tab;
  endfunction

  localparam mtab_t HI_TAB = build_tab(256);
  localparam mtab_t LO_TAB = build_tab(1);

  logic [15:0]   mem_q [MEM_WORDS];
  logic [15:0]   rdata_q;
  logic [AW-1:0] clr_idx_q;
  logic          busy_q;
  logic [AW:0]   sum;
  logic [AW-1:0] idx;

  // addr mod depth = (hi*256 mod depth + lo mod depth), one correction
  always_comb begin
    sum = {1'b0, HI_TAB[req_i.addr[15:8]]} + {1'b0, LO_TAB[req_i.addr[7:0]]};
    if (sum >= (AW+1)'(MEM_WORDS)) begin
      idx = AW'(sum - (AW+1)'(MEM_WORDS));
    end else begin
      idx = sum[AW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b1;
      clr_idx_q <= '0;
    end else if (busy_q) begin
      clr_idx_q <= clr_idx_q + AW'(1);
      if (clr_idx_q == AW'(MEM_WORDS - 1)) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      mem_q[clr_idx_q] <= '0;
    end else if (req_i.wr) begin
      mem_q[idx] <= req_i.wdata;
    end
    if (req_i.rd) rdata_q <= mem_q[idx];
  end

  assign rdata_o = rdata_q;
  assign busy_o  = busy_q;

endmodule

[bench/sixteen_bit_cpu_execute_check.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sixteen_bit_cpu_execute_check
// Watches the instruction, result and program length ports of the execute
// block. It keeps its own counter, register file and data memory, works out
// the status of each accepted instruction and compares every result transfer
// with the oldest outstanding status.
// ----------------------------------------------------------------------------
module sixteen_bit_cpu_execute_check import sbcpu_pkg::*; #(
  parameter int unsigned NUM_REGS  = 16,
  parameter int unsigned MEM_WORDS = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  instr_t      in_data_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  result_t     out_data_i,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  output int          pending_o,
  output int          mismatches_o
);

  logic [15:0] pc;
  logic [15:0] prog_words;
  logic [15:0] regs [NUM_REGS];
  logic [15:0] dmem [MEM_WORDS];
  result_t     status_q [$];

  function automatic logic [15:0] read_reg(input logic [3:0] idx);
    return (idx < NUM_REGS) ? regs[idx] : 16'h0000;
  endfunction

  function automatic void write_reg(input logic [3:0] idx, input logic [15:0] val);
    if (idx < NUM_REGS) regs[idx] = val;
  endfunction

  // Executes one instruction on the local state and returns its status
  function automatic result_t execute_instr(input instr_t ins);
    result_t     res;
    logic        taken;
    logic [15:0] target;
    logic [15:0] ea;
    res    = '0;
    taken  = 1'b0;
    target = '0;
    pc     = pc + 16'd1;
    if (pc > prog_words) begin
      res.halted = 1'b1;
    end else begin
      case (ins.mode)
        OP_NOOP: ;
        OP_ADD:  write_reg(ins.dest_reg, read_reg(ins.src_a_reg) + read_reg(ins.src_b_reg));
        OP_MOVL: write_reg(ins.dest_reg,
                           (read_reg(ins.dest_reg) & HI_MASK) | 16'(ins.immediate));
        OP_MOVH: write_reg(ins.dest_reg, (read_reg(ins.dest_reg) & LO_MASK) |
                                         (16'(ins.immediate) << BYTE_W));
        OP_LW: begin
          ea = read_reg(ins.src_a_reg) + ins.offset;
          write_reg(ins.dest_reg, dmem[ea % MEM_WORDS]);
        end
        OP_SW: begin
          ea = read_reg(ins.dest_reg) + ins.offset;
          dmem[ea % MEM_WORDS] = read_reg(ins.src_a_reg);
        end
        OP_JMP: begin
          taken  = 1'b1;
          target = ins.jump_target;
        end
        OP_JR: begin
          taken  = 1'b1;
          target = read_reg(ins.dest_reg) + 16'(ins.immediate);
        end
        OP_BEQ: begin
          if (read_reg(ins.dest_reg) == read_reg(ins.src_a_reg)) begin
            taken  = 1'b1;
            target = pc + ins.offset;
          end
        end
        OP_INT: begin
          res.syscall_request  = 1'b1;
          res.syscall_number   = ins.dest_reg;
          res.syscall_argument = ins.immediate;
        end
        default: begin
          // parks the counter at the end so the next step halts, or wraps at full length
          res.bad_opcode = 1'b1;
          pc             = prog_words;
        end
      endcase
      if (taken) begin
        res.bad_target = (target > prog_words);
        pc             = target;
      end
    end
    res.next_pc = pc;
    return res;
  endfunction

  task automatic check_field(input string what, input logic [15:0] want_v,
                             input logic [15:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s expected %h, got %h", $time, what, want_v, got_v);
      mismatches_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      pc         = '0;
      prog_words = '0;
      foreach (regs[i]) regs[i] = '0;
      foreach (dmem[i]) dmem[i] = '0;
      status_q.delete();
      pending_o    = 0;
      mismatches_o = 0;
    end else begin
      if (cfg_we_i) prog_words = cfg_wdata_i;
      if (out_valid_i && !out_stall_i) begin
        if (status_q.size() == 0) begin
          $display("%0t: result transfer with nothing outstanding, expected none, got %h",
                   $time, out_data_i);
          mismatches_o++;
        end else begin
          want = status_q.pop_front();
          check_field("next_pc", want.next_pc, out_data_i.next_pc);
          check_field("halted", 16'(want.halted), 16'(out_data_i.halted));
          check_field("bad_opcode", 16'(want.bad_opcode), 16'(out_data_i.bad_opcode));
          check_field("bad_target", 16'(want.bad_target), 16'(out_data_i.bad_target));
          check_field("syscall_request", 16'(want.syscall_request),
                      16'(out_data_i.syscall_request));
          check_field("syscall_number", 16'(want.syscall_number),
                      16'(out_data_i.syscall_number));
          check_field("syscall_argument", 16'(want.syscall_argument),
                      16'(out_data_i.syscall_argument));
        end
      end
      if (in_valid_i && !in_stall_i) status_q.push_back(execute_instr(in_data_i));
      pending_o = status_q.size();
    end
  end

endmodule

[bench/sixteen_bit_cpu_execute_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sixteen_bit_cpu_execute_test
// Drives decoded instructions into the execute block under several program
// lengths: a directed pass over every opcode and field extreme, counter wrap
// through a zero-length program, short programs that halt, and long random
// runs with random gaps, random back-pressure and one long output hold.
// ----------------------------------------------------------------------------
module sixteen_bit_cpu_execute_test;
  import sbcpu_pkg::*;

  localparam int          MEM_WORDS = 4096;
  localparam int          MODE_MAX  = 15;    // highest opcode encoding
  localparam int          LONG_HOLD = 200;
  localparam logic [15:0] FULL_PROG = 16'hFFFF;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  instr_t      in_data   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  result_t     out_data;
  logic        cfg_we    = 1'b0;
  logic [15:0] cfg_wdata = '0;
  int          pending;
  int          mismatches;

  int          items_sent = 0;
  int          cfg_writes = 0;
  int          send_burst = 0;
  int          recv_burst = 0;
  logic        hold_out   = 1'b0;

  always #6 clk = ~clk;

  sixteen_bit_cpu_execute dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  sixteen_bit_cpu_execute_check u_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .pending_o    (pending),
    .mismatches_o (mismatches)
  );

  // Cycles to wait before the next transfer; now and then a run of zeros
  function automatic int next_wait(inout int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 7) == 0) begin
      burst = $urandom_range(8, 30);
      return 0;
    end
    return $urandom_range(0, 12);
  endfunction

  function automatic instr_t make_instr(input logic [3:0] mode, input logic [3:0] rd,
                                        input logic [3:0] ra, input logic [3:0] rb,
                                        input logic [7:0] imm, input logic [15:0] off,
                                        input logic [15:0] tgt);
    instr_t ins;
    ins.mode        = mode;
    ins.dest_reg    = rd;
    ins.src_a_reg   = ra;
    ins.src_b_reg   = rb;
    ins.immediate   = imm;
    ins.offset      = off;
    ins.jump_target = tgt;
    return ins;
  endfunction

  // Random instruction for a program of length lim. Loads and stores mostly
  // use r14/r15 as base with small offsets, which are rarely overwritten, so
  // loads tend to hit stored words. Short programs keep jumps mostly in range.
  function automatic instr_t rand_instr(input logic [15:0] lim);
    instr_t      ins;
    int unsigned pick;
    logic        full;
    full = (lim == FULL_PROG);
    if ($urandom_range(0, 99) < (full ? 10 : 2))
      ins.mode = 4'($urandom_range(int'(OP_INT) + 1, MODE_MAX));
    else
      ins.mode = 4'($urandom_range(int'(OP_NOOP), int'(OP_INT)));
    if (!full && ins.mode == OP_JR && $urandom_range(0, 3) != 0) ins.mode = OP_BEQ;
    ins.dest_reg  = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(14, 15)) :
                                                  4'($urandom_range(0, 13));
    ins.src_a_reg = 4'($urandom);
    ins.src_b_reg = 4'($urandom);
    ins.immediate = 8'($urandom);
    pick = $urandom_range(0, 9);
    if (pick < 6)
      ins.offset = 16'($urandom_range(0, 31));
    else if (pick == 6)
      ins.offset = 16'($urandom_range(1, 15) * MEM_WORDS + $urandom_range(0, 31));
    else
      ins.offset = 16'($urandom);
    if (full || $urandom_range(0, 9) == 0)
      ins.jump_target = 16'($urandom);
    else
      ins.jump_target = 16'($urandom_range(0, lim));
    case (ins.mode)
      OP_LW: if ($urandom_range(0, 2) != 0) ins.src_a_reg = 4'($urandom_range(14, 15));
      OP_SW: if ($urandom_range(0, 2) != 0) ins.dest_reg = 4'($urandom_range(14, 15));
      OP_BEQ: begin
        if ($urandom_range(0, 1) != 0) ins.src_a_reg = ins.dest_reg;
        if (!full && $urandom_range(0, 9) != 0) ins.offset = 16'($urandom_range(0, 15));
      end
      default: ;
    endcase
    return ins;
  endfunction

  task automatic send(input instr_t ins);
    int gap;
    gap = next_wait(send_burst);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= ins;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // Stop offering and wait until every outstanding result has been taken
  task automatic settle();
    in_valid <= 1'b0;
    forever begin
      @(negedge clk);
      if (pending == 0) break;
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [15:0] words);
    cfg_we    <= 1'b1;
    cfg_wdata <= words;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cfg_writes++;
  endtask

  // Result side back-pressure
  initial begin
    int n;
    @(posedge clk);
    forever begin
      n = next_wait(recv_burst);
      if (hold_out) begin
        hold_out = 1'b0;
        n        = LONG_HOLD;
      end
      out_stall <= (n != 0);
      if (n != 0) begin
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  initial begin
    instr_t      plan [$];
    logic [15:0] lim;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    write_cfg(FULL_PROG);

    // directed: every opcode, wrap of sums and addresses, counter wrap
    plan.push_back(make_instr(OP_MOVL, 4'd1, 4'd0, 4'd0, 8'hFF, 16'h0000, 16'h0000));
    plan.push_back(make_instr(OP_MOVH, 4'd1, 4'd0, 4'd0, 8'hFF, 16'h0000, 16'h0000));
    plan.push_back(make_instr(OP_MOVL, 4'd2, 4'd0, 4'd0, 8'h01, 16'h0000, 16'h0000));
    plan.push_back(make_instr(OP_ADD, 4'd3, 4'd1, 4'd2, 8'h00, 16'h0000, 16'h0000));
    plan.push_back(make_instr(OP_ADD, 4'd15, 4'd1, 4'd1, 8'h00, 16'h0000, 16'h0000));
    plan.push_back(make_instr(OP_ADD, 4'd6, 4'd15, 4'd15, 8'h00, 16'h0000, 16'h0000));
    plan.push_back(make_instr(OP_SW, 4'd0, 4'd1, 4'd0, 8'h00, 16'hFFFF, 16'h0000));
    plan.push_back(make_instr(OP_LW, 4'd4, 4'd2, 4'd0, 8'h00, 16'hFFFE, 16'h0000));
    plan.push_back(make_instr(OP_SW, 4'd15, 4'd2, 4'd0, 8'h00, 16'h0003, 16'h0000));
    plan.push_back(make_instr(OP_LW, 4'd5, 4'd0, 4'd0, 8'h00, 16'h1001, 16'h0000));
    plan.push_back(make_instr(OP_BEQ, 4'd0, 4'd3, 4'd0, 8'h00, 16'hFFFF, 16'h0000));
    plan.push_back(make_instr(OP_BEQ, 4'd1, 4'd2, 4'd0, 8'h00, 16'h0005, 16'h0000));
    plan.push_back(make_instr(OP_JMP, 4'd0, 4'd0, 4'd0, 8'h00, 16'h0000, 16'hFFFF));
    plan.push_back(make_instr(OP_NOOP, 4'd15, 4'd15, 4'd15, 8'hFF, 16'hFFFF, 16'hFFFF));
    plan.push_back(make_instr(OP_JR, 4'd2, 4'd0, 4'd0, 8'hFF, 16'h0000, 16'h0000));
    plan.push_back(make_instr(OP_INT, 4'd15, 4'd0, 4'd0, 8'hA5, 16'h0000, 16'h0000));
    plan.push_back(make_instr(OP_INT, 4'd0, 4'd0, 4'd0, 8'h00, 16'h0000, 16'h0000));
    plan.push_back(make_instr(OP_MOVH, 4'd15, 4'd0, 4'd0, 8'h80, 16'h0000, 16'h0000));
    plan.push_back(make_instr(OP_JMP, 4'd0, 4'd0, 4'd0, 8'h00, 16'h0000, 16'h0000));
    // invalid opcodes at full length: counter parks at the end, then wraps
    for (int m = int'(OP_INT) + 1; m <= MODE_MAX; m++) begin
      plan.push_back(make_instr(4'(m), 4'($urandom), 4'($urandom), 4'($urandom),
                                8'($urandom), 16'($urandom), 16'($urandom)));
    end
    foreach (plan[i]) send(plan[i]);

    // long random run, with one long output hold and one full drain
    for (int i = 0; i < 250; i++) begin
      if (i == 60) hold_out = 1'b1;
      if (i == 150) settle();
      send(rand_instr(FULL_PROG));
    end

    // zero-length program: halts until the counter wraps, executes at zero
    send(make_instr(OP_JMP, 4'd0, 4'd0, 4'd0, 8'h00, 16'h0000, 16'hFFFA));
    settle();
    write_cfg(16'h0000);
    repeat (8) send(rand_instr(16'h0000));
    settle();
    write_cfg(FULL_PROG);

    // short programs: halts, bad targets, invalid opcodes near the end
    for (int r = 0; r < 3; r++) begin
      lim = (r == 0) ? 16'd1000 : (r == 1) ? 16'd40 : 16'd1;
      send(make_instr(OP_JMP, 4'd0, 4'd0, 4'd0, 8'h00, 16'h0000, 16'h0000));
      settle();
      write_cfg(lim);
      repeat (40) send(rand_instr(lim));
      settle();
      write_cfg(FULL_PROG);
    end

    for (int i = 0; i < 100; i++) send(rand_instr(FULL_PROG));
    settle();
    repeat (10) @(posedge clk);
    @(negedge clk);

    $display("Executed %0d instructions over %0d program length writes,", items_sent,
             cfg_writes);
    $display("covering halts, counter wrap, bad jumps and a %0d-cycle output hold",
             LONG_HOLD);
    if (pending != 0) $display("%0d results never arrived", pending);
    if (mismatches == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Run timed out with %0d results outstanding", pending);
    $display("Mismatches found");
    $finish;
  end

endmodule

[sim.f]
hdl/sbcpu_pkg.sv
hdl/sbcpu_dmem.sv
hdl/sixteen_bit_cpu_execute.sv
bench/sixteen_bit_cpu_execute_check.sv
bench/sixteen_bit_cpu_execute_test.sv
